FILE: hdl/rto_est_pkg.sv
package rto_est_pkg;

  // Operation codes of the request channel.
  localparam logic [1:0] OP_RTT_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_REXMT_EXPIRY = 2'd1;
  localparam logic [1:0] OP_DELACK_EXPIRY = 2'd2;
  localparam logic [1:0] OP_OTHER_TIMER  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_RTO_MIN     = 2'd0;
  localparam logic [1:0] REG_RTO_MAX     = 2'd1;
  localparam logic [1:0] REG_RTO_DEFAULT = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned SAMPLE_TICKS_W = 14;
  localparam int unsigned SCALED_W    = 17;
  localparam int unsigned BACKOFF_W   = 4;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned US_W        = 32;

  localparam logic [TICKS_W-1:0] RTO_MIN_RESET     = 16'd1;
  localparam logic [TICKS_W-1:0] RTO_MAX_RESET     = 16'd128;
  localparam logic [TICKS_W-1:0] RTO_DEFAULT_RESET = 16'd6;

  // A sample is capped so that SRTT x8 still fits the scaled width.
  localparam logic [SAMPLE_TICKS_W-1:0] SAMPLE_TICKS_CAP = 14'd16383;

  // The backoff multiplier doubles up to 64 and then stays there.
  localparam int unsigned MULT_SHIFT_W = 3;
  localparam logic [MULT_SHIFT_W-1:0] MULT_SHIFT_MAX = 3'd6;
  localparam int unsigned TIMER_FULL_W = TICKS_W + 6;

  typedef logic [SAMPLE_TICKS_W-1:0] sample_ticks_t;

  function automatic logic [MULT_SHIFT_W-1:0] backoff_mult_shift(
    input logic [BACKOFF_W-1:0] shift
  );
    logic [MULT_SHIFT_W-1:0] res;
    if (shift > BACKOFF_W'(MULT_SHIFT_MAX)) begin
      res = MULT_SHIFT_MAX;
    end else begin
      res = shift[MULT_SHIFT_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/rto_est_ticks.sv
module rto_est_ticks #(
  parameter int unsigned TICK_MS = 500
) (
  input  logic [rto_est_pkg::US_W-1:0] rtt_us,
  output rto_est_pkg::sample_ticks_t   sample_ticks
);
  import rto_est_pkg::*;

  // A tick is TICK_MS * 1000 us, always a multiple of 8, so the low three
  // bits are dropped first and the rest is divided by TICK_MS * 125.
  localparam int unsigned     PRE_SHIFT = 3;
  localparam int unsigned     NUM_W     = US_W - PRE_SHIFT;
  localparam longint unsigned Div       = longint'(TICK_MS) * 125;
  localparam int unsigned     DIV_LOG   = $clog2(Div);
  localparam int unsigned     SHIFT     = NUM_W + DIV_LOG;
  localparam longint unsigned Recip     = ((64'd1 << SHIFT) + Div - 64'd1) / Div;
  localparam int unsigned     RECIP_W   = $clog2(Recip + 64'd1);
  localparam int unsigned     PROD_W    = NUM_W + RECIP_W;

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quot;

  // Rounded-up reciprocal with a shift of NUM_W + ceil(log2 divisor) bits
  // gives the exact floor quotient for every numerator of NUM_W bits.
  assign num  = rtt_us[US_W-1:PRE_SHIFT];
  assign prod = PROD_W'(num) * PROD_W'(Recip);
  assign quot = prod >> SHIFT;

  always_comb begin
    if (quot == '0) begin
      sample_ticks = SAMPLE_TICKS_W'(1);
    end else if (quot > PROD_W'(SAMPLE_TICKS_CAP)) begin
      sample_ticks = SAMPLE_TICKS_CAP;
    end else begin
      sample_ticks = quot[SAMPLE_TICKS_W-1:0];
    end
  end

endmodule

FILE: hdl/tcp_rto_estimator_backoff_unit.sv
// A result is registered in the result register after its request
// transaction has passed the input register. One transaction per cycle is
// accepted while the response side does not stall; the tick conversion
// multiplier sits in front of the input register and the estimator update after it.
// Reset (rst, synchronous): no estimate, timeout and backoff zero, clamps
// back to min 1, max 128 and default 6 ticks, both pipeline stages empty.
module tcp_rto_estimator_backoff_unit #(
  parameter int unsigned TICK_MS           = 500,
  parameter int unsigned MAX_BACKOFF_SHIFT = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rto_est_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rto_est_pkg::TICKS_W-1:0]      cfg_data,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [1:0]                           operation,
  input  logic [rto_est_pkg::US_W-1:0]         rtt_sample_us,
  input  logic [rto_est_pkg::SEQ_W-1:0]        send_next,
  input  logic [rto_est_pkg::SEQ_W-1:0]        send_unacked,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic [rto_est_pkg::TICKS_W-1:0]      rto_ticks,
  output logic [rto_est_pkg::TICKS_W-1:0]      rexmt_timer_ticks,
  output logic [rto_est_pkg::BACKOFF_W-1:0]    backoff_count,
  output logic [rto_est_pkg::SEQ_W-1:0]        bytes_outstanding,
  output logic                                 rewind_send_next,
  output logic                                 clear_rtt_measure,
  output logic                                 ack_now
);
  import rto_est_pkg::*;

  // Configuration
  logic [TICKS_W-1:0] rto_min;
  logic [TICKS_W-1:0] rto_max;
  logic [TICKS_W-1:0] rto_default;

  // Input register
  logic               hold_valid;
  logic [1:0]         hold_op;
  sample_ticks_t      hold_ticks;
  logic [SEQ_W-1:0]   hold_snx;
  logic [SEQ_W-1:0]   hold_sua;
  sample_ticks_t      req_ticks;

  // Estimator state
  logic [SCALED_W-1:0]  srtt;
  logic [SCALED_W-1:0]  rttvar;
  logic [TICKS_W-1:0]   rto_current;
  logic [BACKOFF_W-1:0] backoff_shift;

  logic [SCALED_W-1:0]  srtt_next;
  logic [SCALED_W-1:0]  rttvar_next;
  logic [TICKS_W-1:0]   rto_current_next;
  logic [BACKOFF_W-1:0] backoff_shift_next;

  logic                 advance;
  logic [SAMPLE_TICKS_W-1:0] est;
  logic [SAMPLE_TICKS_W-1:0] mag;
  logic [SCALED_W-1:0]  srtt_upd;
  logic [SCALED_W-1:0]  rttvar_upd;
  logic [SCALED_W:0]    rto_full;
  logic [TICKS_W-1:0]   rto_clamped;
  logic [BACKOFF_W-1:0] shift_inc;
  logic [TICKS_W-1:0]   base;
  logic [TIMER_FULL_W-1:0] timer_full;
  logic [TICKS_W-1:0]   timer;

  rto_est_ticks #(
    .TICK_MS(TICK_MS)
  ) u_ticks (
    .rtt_us      (rtt_sample_us),
    .sample_ticks(req_ticks)
  );

  // The result register frees up when it is empty or being taken.
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      rto_min     <= RTO_MIN_RESET;
      rto_max     <= RTO_MAX_RESET;
      rto_default <= RTO_DEFAULT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RTO_MIN:     rto_min     <= cfg_data;
        REG_RTO_MAX:     rto_max     <= cfg_data;
        REG_RTO_DEFAULT: rto_default <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_op    <= operation;
      hold_ticks <= req_ticks;
      hold_snx   <= send_next;
      hold_sua   <= send_unacked;
    end
  end

  // Jacobson/Karels update; a zero SRTT means no sample has been taken yet.
  always_comb begin
    est = srtt[SCALED_W-1:3];
    if (hold_ticks >= est) begin
      mag = hold_ticks - est;
    end else begin
      mag = est - hold_ticks;
    end
    if (srtt == '0) begin
      srtt_upd   = SCALED_W'(hold_ticks) << 3;
      rttvar_upd = SCALED_W'(hold_ticks) << 1;
    end else begin
      srtt_upd   = srtt - SCALED_W'(est) + SCALED_W'(hold_ticks);
      rttvar_upd = rttvar - (rttvar >> 2) + SCALED_W'(mag);
    end
    rto_full = (SCALED_W + 1)'(srtt_upd[SCALED_W-1:3]) + (SCALED_W + 1)'(rttvar_upd);
    // If the clamps cross, rto_min wins below it and rto_max otherwise.
    if (rto_full < (SCALED_W + 1)'(rto_min)) begin
      rto_clamped = rto_min;
    end else if (rto_full > (SCALED_W + 1)'(rto_max)) begin
      rto_clamped = rto_max;
    end else begin
      rto_clamped = rto_full[TICKS_W-1:0];
    end
  end

  always_comb begin
    if (backoff_shift < BACKOFF_W'(MAX_BACKOFF_SHIFT)) begin
      shift_inc = backoff_shift + BACKOFF_W'(1);
    end else begin
      shift_inc = backoff_shift;
    end
    base       = (rto_current != '0) ? rto_current : rto_default;
    timer_full = TIMER_FULL_W'(base) << backoff_mult_shift(shift_inc);
    if (timer_full > TIMER_FULL_W'(rto_max)) begin
      timer = rto_max;
    end else begin
      timer = timer_full[TICKS_W-1:0];
    end
  end

  always_comb begin
    srtt_next          = srtt;
    rttvar_next        = rttvar;
    rto_current_next   = rto_current;
    backoff_shift_next = backoff_shift;
    unique case (hold_op)
      OP_RTT_SAMPLE: begin
        srtt_next        = srtt_upd;
        rttvar_next      = rttvar_upd;
        rto_current_next = rto_clamped;
      end
      OP_REXMT_EXPIRY: begin
        backoff_shift_next = shift_inc;
      end
      OP_DELACK_EXPIRY, OP_OTHER_TIMER: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt          <= '0;
      rttvar        <= '0;
      rto_current   <= '0;
      backoff_shift <= '0;
      rsp_valid     <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hold_valid;
      if (hold_valid) begin
        srtt          <= srtt_next;
        rttvar        <= rttvar_next;
        rto_current   <= rto_current_next;
        backoff_shift <= backoff_shift_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && advance) begin
      rto_ticks         <= rto_current_next;
      backoff_count     <= backoff_shift_next;
      rexmt_timer_ticks <= (hold_op == OP_REXMT_EXPIRY) ? timer : '0;
      bytes_outstanding <= (hold_op == OP_REXMT_EXPIRY) ? (hold_snx - hold_sua) : '0;
      rewind_send_next  <= (hold_op == OP_REXMT_EXPIRY);
      clear_rtt_measure <= (hold_op == OP_REXMT_EXPIRY);
      ack_now           <= (hold_op == OP_DELACK_EXPIRY);
    end
  end

endmodule
